// File: design/set_assoc_lru_cache_sim_defines.svh
// Assertion macros shared by the cache tag store RTL.
`ifndef SET_ASSOC_LRU_CACHE_SIM_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_SIM_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define SACL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define SACL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sacl_pkg.sv
`timescale 1ns / 1ps

package sacl_pkg;

    localparam int MAX_SET_BITS = 8;
    localparam int MAX_WAYS     = 8;
    localparam int ADDR_WIDTH   = 32;

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_STORE  = 2'd1,
        CMD_MODIFY = 2'd2,
        CMD_IFETCH = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS    = 2'd0,
        CFG_WAYS        = 2'd1,
        CFG_OFFSET_BITS = 2'd2,
        CFG_NONE        = 2'd3
    } t_cfg_idx;

    typedef logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] t_tag_row;
    typedef logic [MAX_WAYS-1:0][TIME_W-1:0]     t_time_row;

    function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
        return (v == {TIME_W{1'b1}}) ? v : v + TIME_W'(1);
    endfunction

endpackage

// File: design/set_assoc_lru_cache_sim.sv
`timescale 1ns / 1ps
// Channel   | Signals                                   | Direction
// ----------+-------------------------------------------+----------
// access    | i_in_valid / o_in_ready, i_cmd, i_addr    | in
// result    | o_out_valid / i_out_ready, o_was_* ...    | out
// config    | i_cfg_we, i_cfg_idx, i_cfg_wdata          | in
//
// A counted access reads the set row from the tag and use-time memories
// into registers at the transfer edge, then compares, updates and writes
// it back in the lookup state. An instruction fetch is taken without a lookup.
// Reset clears one valid bit per set; an invalid set reads as all empty.
// A waiting result stalls write-back until the result register frees up.
`include "set_assoc_lru_cache_sim_defines.svh"

module set_assoc_lru_cache_sim
    import sacl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_cmd,
    input  logic [31:0]           i_addr,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_was_hit,
    output logic                  o_was_miss,
    output logic                  o_was_evicted,
    output logic                  o_extra_hit,
    output logic [CNT_W-1:0]      o_total_hits,
    output logic [CNT_W-1:0]      o_total_misses,
    output logic [CNT_W-1:0]      o_total_evictions
);

    typedef enum logic {
        S_IDLE,
        S_LOOK
    } t_state;

    t_state r_state;

    logic [3:0] r_set_bits;
    logic [3:0] r_ways;
    logic [4:0] r_off_bits;

    t_tag_row  mem_tag  [NUM_SETS];
    t_time_row mem_time [NUM_SETS];
    logic [NUM_SETS-1:0] r_row_vld;

    t_tag_row  r_rd_tag;
    t_time_row r_rd_time;
    logic      r_rd_vld;

    logic [SET_W-1:0]      r_set;
    logic [ADDR_WIDTH-1:0] r_tag;
    logic                  r_modify;

    logic [TIME_W-1:0] r_clock;
    logic [CNT_W-1:0]  r_hit_cnt;
    logic [CNT_W-1:0]  r_miss_cnt;
    logic [CNT_W-1:0]  r_evict_cnt;

    logic                  r_out_valid;
    logic                  r_out_hit;
    logic                  r_out_evict;
    logic                  r_out_extra;

    // ---------------- address split ----------------
    logic [ADDR_WIDTH-1:0] addr_in;
    logic [4:0]            sbits;
    logic [5:0]            tag_shift;
    logic [ADDR_WIDTH-1:0] addr_shr;
    logic [SET_W-1:0]      set_mask;
    logic [SET_W-1:0]      set_in;
    logic [ADDR_WIDTH-1:0] tag_in;
    logic                  in_xfer;
    logic                  counted;

    always_comb begin
        addr_in   = ADDR_WIDTH'(i_addr);
        sbits     = (32'(r_set_bits) > MAX_SET_BITS) ? 5'(MAX_SET_BITS) : {1'b0, r_set_bits};
        tag_shift = 6'(r_off_bits) + 6'(sbits);
        addr_shr  = addr_in >> r_off_bits;
        for (int b = 0; b < SET_W; b++) begin
            set_mask[b] = (b < 32'(sbits)) && (b < MAX_SET_BITS);
        end
        set_in    = SET_W'(addr_shr) & set_mask;
        tag_in    = addr_in >> tag_shift;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign counted    = in_xfer && (t_cmd'(i_cmd) != CMD_IFETCH);

    // ---------------- lookup on the read row ----------------
    logic [3:0]          ways_eff;
    logic [MAX_WAYS-1:0] way_act;
    t_time_row           cur_time;
    logic [MAX_WAYS-1:0] is_min;
    logic                hit;
    logic                empty_found;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    empty_way;
    logic [WAY_W-1:0]    victim_way;
    logic [WAY_W-1:0]    sel_way;
    logic                evict;
    logic [TIME_W-1:0]   new_clock;
    t_tag_row            new_tag_row;
    t_time_row           new_time_row;
    logic                done;

    always_comb begin
        if (r_ways == 4'd0) begin
            ways_eff = 4'd1;
        end else if (32'(r_ways) > MAX_WAYS) begin
            ways_eff = 4'(MAX_WAYS);
        end else begin
            ways_eff = r_ways;
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            way_act[w] = (w < 32'(ways_eff));
        end
        cur_time = r_rd_vld ? r_rd_time : '0;

        // lowest way holding the minimum: strictly below earlier ways, not above later ones
        for (int w = 0; w < MAX_WAYS; w++) begin
            is_min[w] = way_act[w];
            for (int v = 0; v < MAX_WAYS; v++) begin
                if (way_act[v] && v < w && !(cur_time[w] < cur_time[v])) begin
                    is_min[w] = 1'b0;
                end
                if (way_act[v] && v > w && (cur_time[w] > cur_time[v])) begin
                    is_min[w] = 1'b0;
                end
            end
        end

        hit         = 1'b0;
        empty_found = 1'b0;
        hit_way     = '0;
        empty_way   = '0;
        victim_way  = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (way_act[w] && cur_time[w] != '0 && r_rd_tag[w] == r_tag) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (way_act[w] && cur_time[w] == '0) begin
                empty_found = 1'b1;
                empty_way   = WAY_W'(w);
            end
            if (is_min[w]) begin
                victim_way = WAY_W'(w);
            end
        end

        evict = !hit && !empty_found;
        priority if (hit) begin
            sel_way = hit_way;
        end else if (empty_found) begin
            sel_way = empty_way;
        end else begin
            sel_way = victim_way;
        end

        new_clock    = sat_inc(r_clock);
        new_tag_row  = r_rd_tag;
        new_time_row = cur_time;
        new_time_row[sel_way] = new_clock;
        if (!hit) begin
            new_tag_row[sel_way] = r_tag;
        end

        done = (r_state == S_LOOK) && (!r_out_valid || i_out_ready);
    end

    // ---------------- counter updates ----------------
    logic [CNT_W+1:0] hit_sum;
    logic [CNT_W-1:0] n_hit_cnt;
    logic [CNT_W-1:0] n_miss_cnt;
    logic [CNT_W-1:0] n_evict_cnt;

    always_comb begin
        hit_sum     = (CNT_W+2)'(r_hit_cnt) + (CNT_W+2)'(r_modify) + (CNT_W+2)'(hit);
        n_hit_cnt   = (hit_sum > (CNT_W+2)'({CNT_W{1'b1}})) ? {CNT_W{1'b1}}
                                                            : CNT_W'(hit_sum);
        n_miss_cnt  = hit ? r_miss_cnt : sat_inc(r_miss_cnt);
        n_evict_cnt = evict ? sat_inc(r_evict_cnt) : r_evict_cnt;
    end

    // ---------------- set memories ----------------
    always_ff @(posedge i_clk) begin
        if (counted) begin
            r_rd_tag  <= mem_tag[set_in];
            r_rd_time <= mem_time[set_in];
        end
        if (done) begin
            mem_tag[r_set]  <= new_tag_row;
            mem_time[r_set] <= new_time_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (counted) begin
            r_set    <= set_in;
            r_tag    <= tag_in;
            r_modify <= (t_cmd'(i_cmd) == CMD_MODIFY);
        end
    end

    // ---------------- control, state and result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_set_bits  <= '0;
            r_ways      <= 4'd1;
            r_off_bits  <= '0;
            r_row_vld   <= '0;
            r_rd_vld    <= 1'b0;
            r_clock     <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SET_BITS:    r_set_bits <= i_cfg_wdata[3:0];
                    CFG_WAYS:        r_ways     <= i_cfg_wdata[3:0];
                    CFG_OFFSET_BITS: r_off_bits <= i_cfg_wdata;
                    default: ;
                endcase
            end
            // drop the result on transfer unless a new one replaces it
            if (o_out_valid && i_out_ready && !done) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (counted) begin
                        r_rd_vld <= r_row_vld[set_in];
                        r_state  <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    // hold here while the previous result is still waiting
                    if (done) begin
                        r_row_vld[r_set] <= 1'b1;
                        r_clock          <= new_clock;
                        r_hit_cnt        <= n_hit_cnt;
                        r_miss_cnt       <= n_miss_cnt;
                        r_evict_cnt      <= n_evict_cnt;
                        r_out_valid      <= 1'b1;
                        r_out_hit        <= hit;
                        r_out_evict      <= evict;
                        r_out_extra      <= r_modify;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_was_hit         = r_out_hit;
    assign o_was_miss        = !r_out_hit;
    assign o_was_evicted     = r_out_evict;
    assign o_extra_hit       = r_out_extra;
    assign o_total_hits      = r_hit_cnt;
    assign o_total_misses    = r_miss_cnt;
    assign o_total_evictions = r_evict_cnt;

    // ---------------- assertions ----------------
    `SACL_ASSERT_NOW(a_evict_is_miss, o_out_valid && o_was_evicted, o_was_miss, "eviction reported on a hit")
    `SACL_ASSERT_NEXT(a_counted_reads, counted, r_state == S_LOOK, "counted access did not enter lookup")
    `SACL_ASSERT_NEXT(a_ifetch_idle, in_xfer && !counted, r_state == S_IDLE && $stable(r_clock), "instruction fetch changed state")
    `SACL_ASSERT_NEXT(a_miss_mono, 1'b1, r_miss_cnt >= $past(r_miss_cnt), "miss count went down")
    `SACL_ASSERT_NEXT(a_result_on_done, done, o_out_valid, "completed lookup produced no result")

endmodule

// File: sim/cache_outcome_monitor.sv
`timescale 1ns / 1ps

module cache_outcome_monitor
    import sacl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [1:0]            i_cmd,
    input  logic [31:0]           i_addr,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_was_hit,
    input  logic                  i_was_miss,
    input  logic                  i_was_evicted,
    input  logic                  i_extra_hit,
    input  logic [CNT_W-1:0]      i_total_hits,
    input  logic [CNT_W-1:0]      i_total_misses,
    input  logic [CNT_W-1:0]      i_total_evictions,
    output int                    o_errors,
    output int                    o_pending
);

    localparam int LINES = NUM_SETS * MAX_WAYS;

    typedef struct packed {
        logic             hit;
        logic             miss;
        logic             evicted;
        logic             extra;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evictions;
    } t_outcome;

    logic [ADDR_WIDTH-1:0] line_tag  [LINES];
    logic [TIME_W-1:0]     line_used [LINES];
    logic [TIME_W-1:0]     use_clock;
    logic [CNT_W-1:0]      hit_cnt;
    logic [CNT_W-1:0]      miss_cnt;
    logic [CNT_W-1:0]      evict_cnt;
    logic [3:0]            set_bits_reg;
    logic [3:0]            ways_reg;
    logic [4:0]            offset_reg;
    t_outcome              expected_outcomes[$];

    function automatic logic [31:0] sat_bump(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    // Look the access up in the shadow tag store and queue its outcome.
    task automatic predict_access(input t_cmd kind, input logic [31:0] a);
        int        set_n;
        int        way_n;
        int        base;
        int        victim;
        int        w;
        logic [63:0] wide;
        logic [63:0] set_sel;
        logic [63:0] tag;
        logic      placed;
        t_outcome  r;
        if (kind == CMD_IFETCH) return;
        set_n = (set_bits_reg > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits_reg);
        way_n = (ways_reg == 0) ? 1 : ((ways_reg > MAX_WAYS) ? MAX_WAYS : int'(ways_reg));
        wide = {32'd0, a};
        set_sel = (wide >> offset_reg) & ((64'd1 << set_n) - 64'd1);
        tag = wide >> (int'(offset_reg) + set_n);
        base = int'(set_sel) * MAX_WAYS;
        r = '0;
        placed = 1'b0;

        use_clock = sat_bump(use_clock);
        if (kind == CMD_MODIFY) hit_cnt = sat_bump(hit_cnt);

        for (w = 0; w < way_n; w++) begin
            if (!r.hit && line_used[base + w] != 0 && line_tag[base + w] == tag[31:0]) begin
                line_used[base + w] = use_clock;
                r.hit = 1'b1;
            end
        end

        if (r.hit) begin
            hit_cnt = sat_bump(hit_cnt);
        end else begin
            miss_cnt = sat_bump(miss_cnt);
            for (w = 0; w < way_n; w++) begin
                if (!placed && line_used[base + w] == 0) begin
                    line_used[base + w] = use_clock;
                    line_tag[base + w] = tag[31:0];
                    placed = 1'b1;
                end
            end
            if (!placed) begin
                // oldest use time loses; ties stay with the lowest way
                victim = base;
                for (w = 1; w < way_n; w++) begin
                    if (line_used[base + w] < line_used[victim]) victim = base + w;
                end
                line_used[victim] = use_clock;
                line_tag[victim] = tag[31:0];
                r.evicted = 1'b1;
                evict_cnt = sat_bump(evict_cnt);
            end
        end

        r.miss      = !r.hit;
        r.extra     = (kind == CMD_MODIFY);
        r.hits      = hit_cnt;
        r.misses    = miss_cnt;
        r.evictions = evict_cnt;
        expected_outcomes.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            o_errors++;
        end
    endtask

    task automatic compare_outcome();
        t_outcome e;
        if (expected_outcomes.size() == 0) begin
            $display("%0t: result transfer with nothing expected: expected none, actual hit=%0b",
                     $time, i_was_hit);
            o_errors++;
            return;
        end
        e = expected_outcomes.pop_front();
        check_field("was_hit",         32'(e.hit),     32'(i_was_hit));
        check_field("was_miss",        32'(e.miss),    32'(i_was_miss));
        check_field("was_evicted",     32'(e.evicted), 32'(i_was_evicted));
        check_field("extra_hit",       32'(e.extra),   32'(i_extra_hit));
        check_field("total_hits",      e.hits,         i_total_hits);
        check_field("total_misses",    e.misses,       i_total_misses);
        check_field("total_evictions", e.evictions,    i_total_evictions);
    endtask

    always @(posedge i_clk) begin
        int i;
        if (!i_rst_n) begin
            for (i = 0; i < LINES; i++) begin
                line_used[i] = '0;
                line_tag[i] = '0;
            end
            use_clock = '0;
            hit_cnt = '0;
            miss_cnt = '0;
            evict_cnt = '0;
            set_bits_reg = 4'd0;
            ways_reg = 4'd1;
            offset_reg = 5'd0;
            expected_outcomes.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SET_BITS:    set_bits_reg = i_cfg_wdata[3:0];
                    CFG_WAYS:        ways_reg = i_cfg_wdata[3:0];
                    CFG_OFFSET_BITS: offset_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_access(t_cmd'(i_cmd), i_addr);
            if (i_out_valid && i_out_ready) compare_outcome();
        end
        o_pending = expected_outcomes.size();
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import sacl_pkg::*;

    localparam int PHASES    = 9;
    localparam int PER_PHASE = 135;
    localparam int LIMIT     = 400000;
    localparam int IDLE_GAP  = 4;
    localparam int DRAIN     = 8;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            cmd = '0;
    logic [31:0]           addr = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  was_hit;
    logic                  was_miss;
    logic                  was_evicted;
    logic                  extra_hit;
    logic [CNT_W-1:0]      total_hits;
    logic [CNT_W-1:0]      total_misses;
    logic [CNT_W-1:0]      total_evictions;

    int errors;
    int pending;
    int cycle_count = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int mode_left = 0;

    // split currently programmed, used only to aim addresses at few sets and tags
    int cur_sb = 0;
    int cur_ways = 1;
    int cur_off = 0;

    always #5 clk = ~clk;

    set_assoc_lru_cache_sim dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_cmd             (cmd),
        .i_addr            (addr),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_was_hit         (was_hit),
        .o_was_miss        (was_miss),
        .o_was_evicted     (was_evicted),
        .o_extra_hit       (extra_hit),
        .o_total_hits      (total_hits),
        .o_total_misses    (total_misses),
        .o_total_evictions (total_evictions)
    );

    cache_outcome_monitor outcome_mon (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_cmd             (cmd),
        .i_addr            (addr),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_was_hit         (was_hit),
        .i_was_miss        (was_miss),
        .i_was_evicted     (was_evicted),
        .i_extra_hit       (extra_hit),
        .i_total_hits      (total_hits),
        .i_total_misses    (total_misses),
        .i_total_evictions (total_evictions),
        .o_errors          (errors),
        .o_pending         (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: drive out_ready with one of three randomly chosen stall patterns.
    always @(negedge clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (stall_mode)
            0:       out_ready = 1'b1;
            1:       out_ready = ($urandom_range(0, 3) != 0);
            default: out_ready = ($urandom_range(0, 5) == 0);
        endcase
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [4:0] val);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Called at a falling edge; hold valid until the transfer.
    task automatic send_access(input t_cmd kind, input logic [31:0] a);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid = 1'b1;
        cmd = kind;
        addr = a;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (IDLE_GAP) @(negedge clk);
    endtask

    function automatic logic [31:0] shaped_addr(input int tag_v);
        int          sb;
        int          set_v;
        logic [63:0] a;
        sb = (cur_sb > MAX_SET_BITS) ? MAX_SET_BITS : cur_sb;
        set_v = $urandom_range(0, ((1 << sb) - 1 < 3) ? (1 << sb) - 1 : 3);
        a = (64'(tag_v) << (cur_off + sb)) | (64'(set_v) << cur_off)
            | (64'($urandom) & ((64'd1 << cur_off) - 64'd1));
        return a[31:0];
    endfunction

    // Mostly reuse a small pool of tags over a few sets so hits and
    // evictions dominate; mix in fully random addresses.
    task automatic random_traffic(input int target);
        int          done;
        int          nw;
        t_cmd        kind;
        logic [31:0] a;
        nw = (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS) ? MAX_WAYS : cur_ways);
        done = 0;
        while (done < target) begin
            kind = ($urandom_range(0, 9) == 0) ? CMD_IFETCH : t_cmd'($urandom_range(0, 2));
            if ($urandom_range(0, 99) < 12) a = $urandom;
            else a = shaped_addr($urandom_range(0, nw + 2));
            send_access(kind, a);
            if (kind != CMD_IFETCH) done++;
        end
    endtask

    initial begin
        int         p;
        logic [4:0] sb;
        logic [4:0] wy;
        logic [4:0] of;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // reset split: one set, one way, no offset
        send_access(CMD_LOAD,   32'h0000_0000);
        send_access(CMD_LOAD,   32'h0000_0000);
        send_access(CMD_STORE,  32'hFFFF_FFFF);
        send_access(CMD_MODIFY, 32'hFFFF_FFFF);
        send_access(CMD_IFETCH, 32'h1234_5678);
        send_access(CMD_MODIFY, 32'h0000_0000);
        send_access(CMD_LOAD,   32'h0000_0001);
        send_access(CMD_STORE,  32'h8000_0000);
        random_traffic(PER_PHASE);

        for (p = 1; p < PHASES; p++) begin
            settle();
            case (p)
                1: begin sb = 5'd8;  wy = 5'd8;  of = 5'd0;  end
                2: begin sb = 5'd2;  wy = 5'd4;  of = 5'd4;  end
                3: begin sb = 5'd15; wy = 5'd15; of = 5'd31; end
                4: begin sb = 5'd0;  wy = 5'd0;  of = 5'd24; end
                5: begin sb = 5'h13; wy = 5'h12; of = 5'd5;  end
                6: begin sb = 5'd8;  wy = 5'd1;  of = 5'd24; end
                7: begin sb = 5'd1;  wy = 5'd8;  of = 5'd2;  end
                default: begin
                    sb = 5'($urandom_range(0, 8));
                    wy = 5'($urandom_range(1, 8));
                    of = 5'($urandom_range(0, 12));
                end
            endcase
            cur_sb = int'(sb[3:0]);
            cur_ways = int'(wy[3:0]);
            cur_off = int'(of);
            write_reg(CFG_SET_BITS, sb);
            write_reg(CFG_WAYS, wy);
            write_reg(CFG_OFFSET_BITS, of);
            // unused index must leave the split alone
            if (p == 4) write_reg(CFG_NONE, 5'h1F);
            send_access(CMD_MODIFY, 32'h0000_0000);
            send_access(CMD_LOAD,   32'hFFFF_FFFF);
            random_traffic(PER_PHASE);
        end

        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/sacl_pkg.sv
design/set_assoc_lru_cache_sim.sv
sim/cache_outcome_monitor.sv
sim/tb.sv
